>>> src/jetp_pkg.sv
// shared types, register map and constants of the julia escape-time pixel block
`default_nettype none
package jetp_pkg;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;
  localparam int ITER_BITS      = 16;
  localparam int COLOR_BITS     = 32;
  localparam int SCALE_BITS     = 24;
  localparam int STEP_BITS      = 31;
  localparam int MUL_DIGIT      = 16;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_ORIGIN_RE    = 4'd0;
  localparam cfg_index_t REG_ORIGIN_IM    = 4'd1;
  localparam cfg_index_t REG_PIXEL_STEP   = 4'd2;
  localparam cfg_index_t REG_CONST_RE     = 4'd3;
  localparam cfg_index_t REG_CONST_IM     = 4'd4;
  localparam cfg_index_t REG_ITER_LIMIT   = 4'd5;
  localparam cfg_index_t REG_COLOR_SCALE  = 4'd6;
  localparam cfg_index_t REG_FORMULA_MODE = 4'd7;

  localparam logic [31:0]           ORIGIN_RE_RST   = 32'd0;
  localparam logic [31:0]           ORIGIN_IM_RST   = 32'd0;
  localparam logic [STEP_BITS-1:0]  PIXEL_STEP_RST  = 31'd1342177;
  localparam logic [31:0]           CONST_RE_RST    = 32'hFE08_3127;
  localparam logic [31:0]           CONST_IM_RST    = 32'd199984415;
  localparam logic [ITER_BITS-1:0]  ITER_LIMIT_RST  = 16'd50;
  localparam logic [SCALE_BITS-1:0] COLOR_SCALE_RST = 24'd1;
  localparam logic                  MODE_RST        = 1'b0;

  typedef struct packed {
    logic [31:0]           origin_re;
    logic [31:0]           origin_im;
    logic [STEP_BITS-1:0]  pixel_step;
    logic [31:0]           const_re;
    logic [31:0]           const_im;
    logic [ITER_BITS-1:0]  iter_limit;
    logic [SCALE_BITS-1:0] color_scale;
    logic                  formula_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic launch1;
    logic step1;
    logic launch2;
    logic step2;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic stop_check;
    logic stop_sum;
    logic cubic;
  } status_t;

endpackage
`default_nettype wire

>>> src/jetp_regs.sv
// configuration register bank with write port
`default_nettype none
module jetp_regs
  import jetp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire cfg_index_t               cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                          cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_RE:    cfg_nxt.origin_re    = cfg_wdata;
        REG_ORIGIN_IM:    cfg_nxt.origin_im    = cfg_wdata;
        REG_PIXEL_STEP:   cfg_nxt.pixel_step   = cfg_wdata[STEP_BITS-1:0];
        REG_CONST_RE:     cfg_nxt.const_re     = cfg_wdata;
        REG_CONST_IM:     cfg_nxt.const_im     = cfg_wdata;
        REG_ITER_LIMIT:   cfg_nxt.iter_limit   = cfg_wdata[ITER_BITS-1:0];
        REG_COLOR_SCALE:  cfg_nxt.color_scale  = cfg_wdata[SCALE_BITS-1:0];
        REG_FORMULA_MODE: cfg_nxt.formula_mode = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re    <= ORIGIN_RE_RST;
      cfg_r.origin_im    <= ORIGIN_IM_RST;
      cfg_r.pixel_step   <= PIXEL_STEP_RST;
      cfg_r.const_re     <= CONST_RE_RST;
      cfg_r.const_im     <= CONST_IM_RST;
      cfg_r.iter_limit   <= ITER_LIMIT_RST;
      cfg_r.color_scale  <= COLOR_SCALE_RST;
      cfg_r.formula_mode <= MODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> src/jetp_mul.sv
// digit-serial sign-magnitude fixed-point multiplier lane
`default_nettype none
module jetp_mul
  import jetp_pkg::*;
#(
  parameter int MW     = 31,
  parameter int RW     = 34,
  parameter int SW     = 46,
  parameter int FRAC   = 28,
  parameter int DIGITS = 2
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic                 step,
  input  wire logic [MW-1:0]        a,
  input  wire logic [MW-1:0]        b,
  input  wire logic                 neg,
  output logic      [RW-1:0]        mag,
  output logic signed [SW-1:0]      res
);

  localparam int BP = DIGITS * MUL_DIGIT;
  localparam int AW = MW + BP;

  logic [MW-1:0] a_r, a_nxt;
  logic [BP-1:0] b_r, b_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic [MW+MUL_DIGIT-1:0] part;

  // top digit first: acc = acc * 2^16 + a * digit
  assign part = (MW+MUL_DIGIT)'(a_r) * (MW+MUL_DIGIT)'(b_r[BP-1 -: MUL_DIGIT]);

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    if (load) begin
      a_nxt   = a;
      b_nxt   = BP'(b);
      acc_nxt = '0;
      neg_nxt = neg;
    end else if (step) begin
      acc_nxt = (acc_r << MUL_DIGIT) + AW'(part);
      b_nxt   = b_r << MUL_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  // drop the fraction bits, truncation toward zero on the magnitude
  assign mag = acc_r[FRAC +: RW];
  assign res = neg_r ? $signed(SW'(0) - SW'(mag)) : $signed(SW'(mag));

endmodule
`default_nettype wire

>>> src/jetp_datapath.sv
// coordinate mapping, iteration registers, multiplier lanes and result registers
`default_nettype none
module jetp_datapath
  import jetp_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int MW         = 31,
  parameter int RW         = 34,
  parameter int SW         = 46,
  parameter int DIGITS     = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic [COORD_BITS-1:0] in_pixel_x,
  input  wire logic [COORD_BITS-1:0] in_pixel_y,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  output logic                       out_valid,
  output logic [COORD_BITS-1:0]      out_x,
  output logic [COORD_BITS-1:0]      out_y,
  output logic [ITER_BITS-1:0]       out_iterations,
  output logic [COLOR_BITS-1:0]      out_pixel_color
);

  localparam int OW = COORD_BITS + STEP_BITS;
  localparam int CW = SCALE_BITS + ITER_BITS;
  localparam logic signed [SW-1:0] TWO =
    {{(SW-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+1){1'b0}}};
  localparam logic signed [SW-1:0] NEG_TWO = -TWO;
  localparam logic [RW:0] FOUR = {{(RW-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

  logic signed [SW-1:0]  re_r, re_nxt, im_r, im_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [ITER_BITS-1:0]  n_r, n_nxt;
  logic                  valid_r;
  logic [COORD_BITS-1:0] ox_r, oy_r;
  logic [ITER_BITS-1:0]  oiter_r;
  logic [COLOR_BITS-1:0] ocolor_r;

  logic [OW-1:0]         offs_x, offs_y;
  logic                  re_neg, im_neg;
  logic [SW-1:0]         re_abs, im_abs;
  logic [MW-1:0]         re_mag, im_mag, kim_mag;
  logic [RW-1:0]         l0_mag, l1_mag, l2_mag;
  logic signed [SW-1:0]  l0_res, l1_res, l2_res;
  logic [RW:0]           mag_sum;
  logic [CW-1:0]         color_full;
  logic [MW-1:0]         l0_a;
  logic                  l0_neg;

  // start point: origin plus coordinate times step
  assign offs_x = OW'(in_pixel_x) * OW'(cfg.pixel_step);
  assign offs_y = OW'(in_pixel_y) * OW'(cfg.pixel_step);

  assign re_neg  = re_r[SW-1];
  assign im_neg  = im_r[SW-1];
  assign re_abs  = re_neg ? SW'(0) - re_r : re_r;
  assign im_abs  = im_neg ? SW'(0) - im_r : im_r;
  assign re_mag  = re_abs[MW-1:0];
  assign im_mag  = im_abs[MW-1:0];
  assign kim_mag = cfg.formula_mode ? (im_mag << 1) + im_mag : im_mag << 1;

  // lane 0 squares re, then forms rr * re in cubic mode
  assign l0_a   = cmd.launch2 ? l0_mag[MW-1:0] : re_mag;
  assign l0_neg = cmd.launch2 ? re_neg : 1'b0;

  jetp_mul #(.MW(MW), .RW(RW), .SW(SW), .FRAC(FRAC_BITS), .DIGITS(DIGITS)) u_lane0 (
    .clk  (clk),
    .load (cmd.launch1 | cmd.launch2),
    .step (cmd.step1 | cmd.step2),
    .a    (l0_a),
    .b    (re_mag),
    .neg  (l0_neg),
    .mag  (l0_mag),
    .res  (l0_res)
  );

  jetp_mul #(.MW(MW), .RW(RW), .SW(SW), .FRAC(FRAC_BITS), .DIGITS(DIGITS)) u_lane1 (
    .clk  (clk),
    .load (cmd.launch1),
    .step (cmd.step1),
    .a    (im_mag),
    .b    (im_mag),
    .neg  (1'b0),
    .mag  (l1_mag),
    .res  (l1_res)
  );

  jetp_mul #(.MW(MW), .RW(RW), .SW(SW), .FRAC(FRAC_BITS), .DIGITS(DIGITS)) u_lane2 (
    .clk  (clk),
    .load (cmd.launch1),
    .step (cmd.step1),
    .a    (kim_mag),
    .b    (re_mag),
    .neg  (re_neg ^ im_neg),
    .mag  (l2_mag),
    .res  (l2_res)
  );

  assign mag_sum = {1'b0, l0_mag} + {1'b0, l1_mag};

  always_comb begin
    st.stop_check = (n_r >= cfg.iter_limit) || (re_r >= TWO) || (re_r <= NEG_TWO) ||
                    (im_r >= TWO) || (im_r <= NEG_TWO);
    st.stop_sum   = (mag_sum >= FOUR);
    st.cubic      = cfg.formula_mode;
  end

  assign color_full = CW'(cfg.color_scale) * CW'(n_r);

  always_comb begin
    re_nxt = re_r;
    im_nxt = im_r;
    px_nxt = px_r;
    py_nxt = py_r;
    n_nxt  = n_r;
    if (cmd.load) begin
      px_nxt = in_pixel_x;
      py_nxt = in_pixel_y;
      re_nxt = SW'($signed(cfg.origin_re)) + $signed(SW'(offs_x));
      im_nxt = SW'($signed(cfg.origin_im)) + $signed(SW'(offs_y));
      n_nxt  = '0;
    end else if (cmd.update) begin
      // same form for both modes: lane 0 holds rr or rr*re
      re_nxt = l0_res - l1_res + SW'($signed(cfg.const_re));
      im_nxt = l2_res + SW'($signed(cfg.const_im));
      n_nxt  = n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    re_r <= re_nxt;
    im_r <= im_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
    n_r  <= n_nxt;
    if (cmd.finish) begin
      ox_r     <= px_r;
      oy_r     <= py_r;
      oiter_r  <= n_r;
      ocolor_r <= color_full[COLOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  assign out_valid       = valid_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_iterations  = oiter_r;
  assign out_pixel_color = ocolor_r;

endmodule
`default_nettype wire

>>> src/jetp_ctrl.sv
// sequencing state machine for one pixel evaluation
`default_nettype none
module jetp_ctrl
  import jetp_pkg::*;
#(
  parameter int DIGITS = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire status_t st,
  output logic         busy,
  output cmd_t         cmd
);

  localparam int DCW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [DCW-1:0] LAST = DCW'(DIGITS - 1);

  state_t         state_r, state_nxt;
  logic [DCW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.stop_check) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.launch1 = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.step1 = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SUM: begin
        if (st.stop_sum) begin
          state_nxt = ST_DONE;
        end else if (st.cubic) begin
          cmd.launch2 = 1'b1;
          state_nxt   = ST_MUL2;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_MUL2: begin
        cmd.step2 = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

>>> src/julia_escape_time_pixel.sv
// top level of the julia escape-time pixel evaluator
//
//   channel   ports                                          handshake
//   ------    ---------------------------------------------  ----------------------------
//   input     in_pixel_x, in_pixel_y                         start high while busy low
//   result    out_x, out_y, out_iterations, out_pixel_color  out_valid, one cycle, no stall
//   config    cfg_index, cfg_wdata                           cfg_we, written at the edge
//
// a request loops through check, multiply, magnitude test and update, with a second multiply in cubic mode,
//   until the iteration limit, the escape check or the magnitude test ends the run
// D = ceil((FRAC_BITS+3)/16) digit steps of the digit-serial multiplier lanes, 2 by default
// reset (rst_n low, synchronous) restores the register defaults and idles the sequencer
// the receiver cannot stall: each result shows for one cycle, and a new request may be
//   taken in that same cycle
`default_nettype none
module julia_escape_time_pixel
  import jetp_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request side
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [COORD_BITS-1:0]    in_pixel_x,
  input  wire logic [COORD_BITS-1:0]    in_pixel_y,
  // result side
  output logic                          out_valid,
  output logic [COORD_BITS-1:0]         out_x,
  output logic [COORD_BITS-1:0]         out_y,
  output logic [ITER_BITS-1:0]          out_iterations,
  output logic [COLOR_BITS-1:0]         out_pixel_color,
  // configuration write port
  input  wire logic                     cfg_we,
  input  wire cfg_index_t               cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // multiplier operand magnitude: 3*im stays below 2^(FRAC_BITS+3)
  localparam int MW     = FRAC_BITS + 3;
  // shifted product magnitude width
  localparam int RW     = FRAC_BITS + 6;
  // signed state width, covers the far start point and every iterate
  localparam int SW     = (FRAC_BITS + 8 > COORD_BITS + 34) ? FRAC_BITS + 8 : COORD_BITS + 34;
  // digit steps per multiply
  localparam int DIGITS = (MW + MUL_DIGIT - 1) / MUL_DIGIT;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  // register bank
  jetp_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: check, multiply, magnitude test, update
  jetp_ctrl #(.DIGITS(DIGITS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  // arithmetic and result registers
  jetp_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MW         (MW),
    .RW         (RW),
    .SW         (SW),
    .DIGITS     (DIGITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_iterations  (out_iterations),
    .out_pixel_color (out_pixel_color)
  );

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // a result is only shown once the sequencer is back at idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // one strobe per request, never two in a row
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

  // the sequencer issues at most one datapath command per cycle
  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.launch1, cmd.step1, cmd.launch2, cmd.step2,
              cmd.update, cmd.finish}))
    else $error("overlapping datapath commands");

endmodule
`default_nettype wire
